>>> hdl/esc_pkg.sv
// shared types, constants and helpers for the epoch seconds to calendar converter
`timescale 1ns / 1ps

package esc_pkg;

    localparam int STAGES      = 10;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 17;
    localparam int ZONE_W      = 17;

    localparam logic [CFG_INDEX_W-1:0] REG_ZONE_OFFSET = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BCD_MODE    = 4'd1;

    localparam logic [7:0]  BASE_YEAR      = 8'd70;
    localparam logic [15:0] HOURS_PER_YEAR = 16'd8760;
    localparam logic [15:0] HOURS_PER_LEAP = 16'd8784;
    localparam logic [15:0] HOURS_PER_QUAD = 16'd35064;
    localparam logic [15:0] HOURS_TWO_YEARS   = 16'(2 * 8760);
    localparam logic [15:0] HOURS_THREE_YEARS = 16'(2 * 8760 + 8784);

    // reciprocals: floor(x / d) == (x * m) >> s over the stated input width
    localparam logic [30:0] RECIP_15_X30   = 31'd1145324613;  // s = 34
    localparam logic [24:0] RECIP_15_X24   = 25'd17895698;    // s = 28
    localparam logic [17:0] RECIP_4383_X17 = 18'd244979;      // s = 30
    localparam logic [11:0] RECIP_3_X11    = 12'd2731;        // s = 13

    localparam logic [8:0] MONTH_START [12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    typedef struct packed {
        logic [5:0] sec;
        logic [5:0] min;
        logic [4:0] hour;
        logic [4:0] mday;
        logic [3:0] mon;
        logic [7:0] year;
    } cal_bin_t;

    typedef struct packed {
        logic [6:0] second;
        logic [6:0] minute;
        logic [5:0] hour;
        logic [5:0] day_of_month;
        logic [4:0] month;
        logic [7:0] year;
    } cal_out_t;

    // two bcd digits of a value below 100
    function automatic logic [7:0] to_bcd(input logic [6:0] v);
        logic [14:0] scaled;
        logic [3:0]  tens;
        logic [3:0]  ones;
        scaled = 15'(v) * 15'd205;
        tens   = scaled[14:11];
        ones   = 4'(v - 7'(tens * 4'd10));
        return {tens, ones};
    endfunction

endpackage

>>> hdl/esc_if.sv
// channel interfaces for timestamps, calendar words and register writes
`timescale 1ns / 1ps

interface esc_stamp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] epoch_seconds;

    modport source (output valid, output epoch_seconds, input ready);
    modport sink (input valid, input epoch_seconds, output ready);
endinterface

interface esc_cal_if;
    logic       valid;
    logic       ready;
    logic [6:0] second;
    logic [6:0] minute;
    logic [5:0] hour;
    logic [5:0] day_of_month;
    logic [4:0] month;
    logic [7:0] year;

    modport source (output valid, output second, output minute, output hour,
                    output day_of_month, output month, output year, input ready);
    modport sink (input valid, input second, input minute, input hour,
                  input day_of_month, input month, input year, output ready);
endinterface

interface esc_cfg_if import esc_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> hdl/epoch_seconds_to_calendar_top.sv
// epoch seconds to calendar date converter, ten stage pipeline
`timescale 1ns / 1ps

// Converts a signed 32-bit count of seconds since 1970 into second, minute, hour,
// day, month and year, after subtracting the zone offset register; times before
// the epoch read as 1970-01-01 00:00:00. The datapath is a ten stage pipeline:
// every divide by 60, by 3600, by the four-year block and by 24 is a multiply by
// a reciprocal with its own register stage, then the year walk, the month search
// and the output formatter. One word enters per cycle unless back-pressure has
// filled every stage; back-pressure on the output stalls only the stages
// that are full. The zone offset applies to words accepted after a write and the
// output mode to words leaving after it, so writes should only be issued while no
// word is in flight.
module epoch_seconds_to_calendar_top
    import esc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    esc_stamp_if.sink  stamp,
    esc_cal_if.source  calendar,
    esc_cfg_if.sink    cfg
);

    logic [ZONE_W-1:0] zone_reg;
    logic              bcd_reg;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] load_en;

    // stage payloads
    logic [31:0] t_s1_reg;
    logic [25:0] q1_s2_reg;
    logic [5:0]  tlo_s2_reg;
    logic [19:0] q2_s3_reg;
    logic [5:0]  q1lo_s3_reg;
    logic [19:0] hours_s4_reg;
    logic [4:0]  quad_s4_reg;
    logic [15:0] rem_s5_reg;
    logic [4:0]  quad_s5_reg;
    logic [13:0] hoy_s6_reg;
    logic        leap_s6_reg;
    logic [8:0]  doy_s7_reg;
    logic        leap_s7_reg;
    logic [8:0]  day_s8_reg;
    logic [3:0]  mon_s8_reg;
    logic        feb29_s8_reg;
    cal_bin_t    done_s3_reg;
    cal_bin_t    done_s4_reg;
    cal_bin_t    done_s5_reg;
    cal_bin_t    done_s6_reg;
    cal_bin_t    done_s7_reg;
    cal_bin_t    done_s8_reg;
    cal_bin_t    done_s9_reg;
    cal_out_t    out_reg;

    logic [32:0] wall_time;
    logic [31:0] t_s1_next;
    logic [60:0] prod1;
    logic [48:0] prod2;
    logic [34:0] prod3;
    logic [22:0] prod4;
    logic [15:0] rem_s5_next;
    logic [13:0] hoy_s6_next;
    logic [1:0]  yoff;
    logic [8:0]  qd;
    logic [8:0]  day_s8_next;
    logic [3:0]  mon_s8_next;
    logic        feb29_s8_next;
    cal_bin_t    done_s3_next;
    cal_bin_t    done_s4_next;
    cal_bin_t    done_s6_next;
    cal_bin_t    done_s7_next;
    cal_bin_t    done_s9_next;
    cal_out_t    out_next;

    // register writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_reg <= '0;
            bcd_reg  <= 1'b0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_ZONE_OFFSET: zone_reg <= cfg.data[ZONE_W-1:0];
                REG_BCD_MODE:    bcd_reg  <= cfg.data[0];
                default:         ;
            endcase
        end
    end

    // per stage ready chain
    always_comb
    begin
        load_en[STAGES-1] = !valid_reg[STAGES-1] || calendar.ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            load_en[k] = !valid_reg[k] || load_en[k+1];
        end
    end

    assign stamp.ready = load_en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (load_en[0])
            begin
                valid_reg[0] <= stamp.valid;
            end
            for (int k = 1; k < STAGES; k++)
            begin
                if (load_en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // s1: local time, clamped at zero
    assign wall_time = {stamp.epoch_seconds[31], stamp.epoch_seconds}
                     - {{(33 - ZONE_W){zone_reg[ZONE_W-1]}}, zone_reg};
    assign t_s1_next = wall_time[32] ? 32'd0 : wall_time[31:0];

    // s2: total minutes
    assign prod1 = 61'(t_s1_reg[31:2]) * 61'(RECIP_15_X30);

    // s3: seconds, total hours
    assign prod2 = 49'(q1_s2_reg[25:2]) * 49'(RECIP_15_X24);

    always_comb
    begin
        done_s3_next     = '0;
        done_s3_next.sec = tlo_s2_reg - 6'(q1_s2_reg[5:0] * 6'd60);
    end

    // s4: minutes, four-year block
    assign prod3 = 35'(q2_s3_reg[19:3]) * 35'(RECIP_4383_X17);

    always_comb
    begin
        done_s4_next     = done_s3_reg;
        done_s4_next.min = q1lo_s3_reg - 6'(q2_s3_reg[5:0] * 6'd60);
    end

    // s5: hours inside the block
    assign rem_s5_next = hours_s4_reg[15:0] - 16'(quad_s4_reg * HOURS_PER_QUAD);

    // s6: year walk
    always_comb
    begin
        if (rem_s5_reg < HOURS_PER_YEAR)
        begin
            yoff        = 2'd0;
            hoy_s6_next = rem_s5_reg[13:0];
        end
        else if (rem_s5_reg < HOURS_TWO_YEARS)
        begin
            yoff        = 2'd1;
            hoy_s6_next = 14'(rem_s5_reg - HOURS_PER_YEAR);
        end
        else if (rem_s5_reg < HOURS_THREE_YEARS)
        begin
            yoff        = 2'd2;
            hoy_s6_next = 14'(rem_s5_reg - HOURS_TWO_YEARS);
        end
        else
        begin
            yoff        = 2'd3;
            hoy_s6_next = 14'(rem_s5_reg - HOURS_THREE_YEARS);
        end
        done_s6_next      = done_s5_reg;
        done_s6_next.year = BASE_YEAR + {1'b0, quad_s5_reg, 2'b00} + {6'd0, yoff};
    end

    // s7: hour of day, day of year
    assign prod4 = 23'(hoy_s6_reg[13:3]) * 23'(RECIP_3_X11);
    assign qd    = prod4[21:13];

    always_comb
    begin
        done_s7_next      = done_s6_reg;
        done_s7_next.hour = hoy_s6_reg[4:0] - 5'(qd[4:0] * 5'd24);
    end

    // s8: leap day and month search
    always_comb
    begin
        feb29_s8_next = leap_s7_reg && (doy_s7_reg == 9'd60);
        if (leap_s7_reg && (doy_s7_reg > 9'd60))
        begin
            day_s8_next = doy_s7_reg - 9'd1;
        end
        else
        begin
            day_s8_next = doy_s7_reg;
        end
        mon_s8_next = 4'd0;
        for (int i = 1; i < 12; i++)
        begin
            mon_s8_next = mon_s8_next + 4'(day_s8_next > MONTH_START[i]);
        end
    end

    // s9: day of month
    always_comb
    begin
        done_s9_next = done_s8_reg;
        if (feb29_s8_reg)
        begin
            done_s9_next.mon  = 4'd1;
            done_s9_next.mday = 5'd29;
        end
        else
        begin
            done_s9_next.mon  = mon_s8_reg;
            done_s9_next.mday = 5'(day_s8_reg - MONTH_START[mon_s8_reg]);
        end
    end

    // s10: output word
    esc_fmt u_fmt (
        .bcd_mode (bcd_reg),
        .bin      (done_s9_reg),
        .word     (out_next)
    );

    always_ff @(posedge clk)
    begin
        if (load_en[0])
        begin
            t_s1_reg <= t_s1_next;
        end
        if (load_en[1])
        begin
            q1_s2_reg  <= prod1[59:34];
            tlo_s2_reg <= t_s1_reg[5:0];
        end
        if (load_en[2])
        begin
            q2_s3_reg   <= prod2[47:28];
            q1lo_s3_reg <= q1_s2_reg[5:0];
            done_s3_reg <= done_s3_next;
        end
        if (load_en[3])
        begin
            hours_s4_reg <= q2_s3_reg;
            quad_s4_reg  <= prod3[34:30];
            done_s4_reg  <= done_s4_next;
        end
        if (load_en[4])
        begin
            rem_s5_reg  <= rem_s5_next;
            quad_s5_reg <= quad_s4_reg;
            done_s5_reg <= done_s4_reg;
        end
        if (load_en[5])
        begin
            hoy_s6_reg  <= hoy_s6_next;
            leap_s6_reg <= (yoff == 2'd2);
            done_s6_reg <= done_s6_next;
        end
        if (load_en[6])
        begin
            doy_s7_reg  <= qd + 9'd1;
            leap_s7_reg <= leap_s6_reg;
            done_s7_reg <= done_s7_next;
        end
        if (load_en[7])
        begin
            day_s8_reg   <= day_s8_next;
            mon_s8_reg   <= mon_s8_next;
            feb29_s8_reg <= feb29_s8_next;
            done_s8_reg  <= done_s7_reg;
        end
        if (load_en[8])
        begin
            done_s9_reg <= done_s9_next;
        end
        if (load_en[9])
        begin
            out_reg <= out_next;
        end
    end

    assign calendar.valid        = valid_reg[STAGES-1];
    assign calendar.second       = out_reg.second;
    assign calendar.minute       = out_reg.minute;
    assign calendar.hour         = out_reg.hour;
    assign calendar.day_of_month = out_reg.day_of_month;
    assign calendar.month        = out_reg.month;
    assign calendar.year         = out_reg.year;

    // checks
    a_accept_enters_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        stamp.valid && stamp.ready |=> valid_reg[0])
        else $error("accepted word did not enter the first stage");

    a_quad_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[3] |-> quad_s4_reg <= 5'd17)
        else $error("four-year block count out of range");

    a_hour_of_year: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[5] |-> hoy_s6_reg < 14'(HOURS_PER_LEAP))
        else $error("hour of year beyond one year");

    a_day_of_year: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[7] && !feb29_s8_reg |-> day_s8_reg >= 9'd1 && day_s8_reg <= 9'd365)
        else $error("day of year out of range");

    a_month_day: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[8] |-> done_s9_reg.mon <= 4'd11 && done_s9_reg.mday != 5'd0)
        else $error("month or day of month out of range");

endmodule

>>> hdl/esc_fmt.sv
// output formatter: binary calendar fields or bcd rtc bytes
`timescale 1ns / 1ps

module esc_fmt
    import esc_pkg::*;
(
    input  logic     bcd_mode,
    input  cal_bin_t bin,
    output cal_out_t word
);

    logic [6:0] year_mod;
    logic [6:0] month_num;

    assign year_mod  = (bin.year >= 8'd100) ? 7'(bin.year - 8'd100) : bin.year[6:0];
    assign month_num = 7'(bin.mon) + 7'd1;

    always_comb
    begin
        if (bcd_mode)
        begin
            word.second       = 7'(to_bcd({1'b0, bin.sec}));
            word.minute       = 7'(to_bcd({1'b0, bin.min}));
            word.hour         = 6'(to_bcd({2'b00, bin.hour}));
            word.day_of_month = 6'(to_bcd({2'b00, bin.mday}));
            word.month        = 5'(to_bcd(month_num));
            word.year         = to_bcd(year_mod);
        end
        else
        begin
            word.second       = {1'b0, bin.sec};
            word.minute       = {1'b0, bin.min};
            word.hour         = {1'b0, bin.hour};
            word.day_of_month = {1'b0, bin.mday};
            word.month        = {1'b0, bin.mon};
            word.year         = bin.year;
        end
    end

endmodule
